// ===== src/pdm_pkg.sv =====
// Shared types, constants and the dB lookup for the block peak meter.
package pdm_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int PEAK_W = 16;
   localparam int COEFF_W = 16;
   localparam int DECAY_W = 32;
   localparam int FRAC_W = 16;
   localparam int LEVEL_W = 8;
   localparam int PROD_W = DECAY_W + COEFF_W;

   // Block length default
   localparam int BLOCK_SAMPLES_DEFAULT = 64;

   // Level scaling: k = floor(peak * LEVEL_STEPS / FULL_SCALE)
   localparam int LEVEL_STEPS = 100;
   localparam int FULL_SCALE = 32767;
   localparam int FULL_SCALE_SHIFT = 15;
   localparam int PEAK_MAX = 32768;
   localparam int SCALED_W = $clog2(PEAK_MAX * LEVEL_STEPS + 1);
   localparam int Q_W = SCALED_W - FULL_SCALE_SHIFT;
   localparam int K_W = Q_W + 1;
   localparam int BOUND_W = K_W + FULL_SCALE_SHIFT;
   localparam int DB_MAG_W = 6;

   // Queue depths
   localparam int MID_DEPTH = 2;
   localparam int OUT_DEPTH = 2;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DECAY_COEFF = 1'b0,
      CSR_FLOOR_DB    = 1'b1
   } csr_index_type;

   localparam logic [COEFF_W-1:0] DECAY_COEFF_RESET = 16'd58982;
   localparam logic signed [LEVEL_W-1:0] FLOOR_DB_RESET = -8'sd40;

   // One finished block
   typedef struct packed {
      logic [PEAK_W-1:0]         block_peak;
      logic [DECAY_W-1:0]        decayed_peak;
      logic signed [LEVEL_W-1:0] level_db;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

   // floor(20 * log10(LEVEL_STEPS / k)) for k in 1..LEVEL_STEPS
   function automatic logic [DB_MAG_W-1:0] db_below(input logic [K_W-1:0] k);
      logic [DB_MAG_W-1:0] n;
      case (k) inside
         8'd1:          n = 6'd40;
         8'd2:          n = 6'd33;
         8'd3:          n = 6'd30;
         8'd4:          n = 6'd27;
         8'd5:          n = 6'd26;
         8'd6:          n = 6'd24;
         8'd7:          n = 6'd23;
         8'd8:          n = 6'd21;
         [8'd9:8'd10]:  n = 6'd20;
         8'd11:         n = 6'd19;
         8'd12:         n = 6'd18;
         [8'd13:8'd14]: n = 6'd17;
         8'd15:         n = 6'd16;
         [8'd16:8'd17]: n = 6'd15;
         [8'd18:8'd19]: n = 6'd14;
         [8'd20:8'd22]: n = 6'd13;
         [8'd23:8'd25]: n = 6'd12;
         [8'd26:8'd28]: n = 6'd11;
         [8'd29:8'd31]: n = 6'd10;
         [8'd32:8'd35]: n = 6'd9;
         [8'd36:8'd39]: n = 6'd8;
         [8'd40:8'd44]: n = 6'd7;
         [8'd45:8'd50]: n = 6'd6;
         [8'd51:8'd56]: n = 6'd5;
         [8'd57:8'd63]: n = 6'd4;
         [8'd64:8'd70]: n = 6'd3;
         [8'd71:8'd79]: n = 6'd2;
         [8'd80:8'd89]: n = 6'd1;
         default:       n = 6'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== src/pdm_queue.sv =====
// Small register queue used between the front and back ends and at the output.
module pdm_queue #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== src/pdm_front.sv =====
// Front end: sample magnitude, running block maximum and block counter.
module pdm_front #(
   parameter int BLOCK_SAMPLES = pdm_pkg::BLOCK_SAMPLES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic signed [pdm_pkg::SAMPLE_W-1:0] sample,
   output logic                                peak_push,
   output logic [pdm_pkg::PEAK_W-1:0]          peak_word
);
   import pdm_pkg::*;

   localparam int CNT_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;

   logic [PEAK_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PEAK_W-1:0] mag;
   logic [PEAK_W-1:0] new_peak;
   logic              last;

   // |sample|; the most negative sample gives 32768, which still fits
   always_comb begin
      mag      = sample[SAMPLE_W-1] ? PEAK_W'(~sample + 1'b1) : PEAK_W'(sample);
      new_peak = (mag > acc_ff) ? mag : acc_ff;
      last     = (cnt_ff == CNT_W'(BLOCK_SAMPLES - 1));
   end

   // accumulate, and hand the block maximum on at the block end
   always_comb begin
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      peak_push = 1'b0;
      peak_word = new_peak;
      if (accept) begin
         if (last) begin
            acc_in    = '0;
            cnt_in    = '0;
            peak_push = 1'b1;
         end else begin
            acc_in = new_peak;
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== src/pdm_back.sv =====
// Back end: decayed peak hold, level index and dB lookup, plus the config registers.
module pdm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [pdm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pdm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              peak_empty,
   input  logic [pdm_pkg::PEAK_W-1:0]        peak_word,
   output logic                              peak_pop,
   input  logic                              res_full,
   output logic                              res_push,
   output pdm_pkg::result_type               res_word
);
   import pdm_pkg::*;

   logic [COEFF_W-1:0]        decay_coeff_ff, decay_coeff_in;
   logic signed [LEVEL_W-1:0] floor_db_ff, floor_db_in;
   logic [DECAY_W-1:0]        held_ff, held_in;

   logic                      s2_valid_ff, s2_valid_in;
   logic [PEAK_W-1:0]         s2_peak_ff;
   logic [DECAY_W-1:0]        s2_decay_ff;
   logic [SCALED_W-1:0]       s2_scaled_ff;

   logic                      s2_adv;
   logic [DECAY_W-1:0]        p;
   logic [PROD_W-1:0]         prod;
   logic [DECAY_W-1:0]        shrunk;
   logic [DECAY_W-1:0]        nd;
   logic [SCALED_W-1:0]       scaled;
   logic [Q_W-1:0]            q0;
   logic [K_W-1:0]            q1;
   logic [BOUND_W-1:0]        bound;
   logic [K_W-1:0]            k_raw;
   logic [K_W-1:0]            k;

   // config registers
   always_comb begin
      decay_coeff_in = decay_coeff_ff;
      floor_db_in    = floor_db_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DECAY_COEFF: decay_coeff_in = csr_wdata[COEFF_W-1:0];
            CSR_FLOOR_DB:    floor_db_in = csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_coeff_ff <= DECAY_COEFF_RESET;
         floor_db_ff    <= FLOOR_DB_RESET;
      end else begin
         decay_coeff_ff <= decay_coeff_in;
         floor_db_ff    <= floor_db_in;
      end
   end

   // stage handshake: take a peak word when stage two is free or draining
   assign s2_adv   = s2_valid_ff && !res_full;
   assign peak_pop = !peak_empty && (!s2_valid_ff || s2_adv);
   assign res_push = s2_adv;

   // stage one: decay of the held value, and peak scaled by the step count
   always_comb begin
      p      = {peak_word, FRAC_W'(0)};
      prod   = PROD_W'(held_ff) * PROD_W'(decay_coeff_ff);
      shrunk = prod[PROD_W-1 -: DECAY_W];
      if (p < held_ff) begin
         nd = (shrunk < p) ? p : shrunk;
      end else begin
         nd = p;
      end
      scaled      = SCALED_W'(peak_word) * SCALED_W'(LEVEL_STEPS);
      held_in     = peak_pop ? nd : held_ff;
      s2_valid_in = peak_pop ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         held_ff     <= held_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (peak_pop) begin
         s2_peak_ff   <= peak_word;
         s2_decay_ff  <= nd;
         s2_scaled_ff <= scaled;
      end
   end

   // stage two: divide by full scale (shift, then one-step correction), clamp, look up
   always_comb begin
      q0    = s2_scaled_ff[SCALED_W-1 -: Q_W];
      q1    = K_W'(q0) + 1'b1;
      bound = (BOUND_W'(q1) << FULL_SCALE_SHIFT) - BOUND_W'(q1);
      k_raw = (bound <= BOUND_W'(s2_scaled_ff)) ? q1 : K_W'(q0);
      k     = (k_raw > K_W'(LEVEL_STEPS)) ? K_W'(LEVEL_STEPS) : k_raw;

      res_word.block_peak   = s2_peak_ff;
      res_word.decayed_peak = s2_decay_ff;
      if (k == '0) begin
         res_word.level_db = floor_db_ff;
      end else begin
         res_word.level_db = LEVEL_W'(0) - LEVEL_W'(db_below(k));
      end
   end

endmodule

// ===== src/block_peak_decay_db_meter.sv =====
// Top level of the block peak meter with decaying peak hold and dB level.
//
// Usage:
//   Samples enter through a queue-style port: a word is taken at a clock edge
//   with req_push high and req_full low, so at most one sample per cycle.
//   After every BLOCK_SAMPLES samples one result word appears on the rsp_
//   ports while rsp_empty is low; it leaves at an edge with rsp_pop high.
//   Path: a block maximum passes the middle queue, the stage-two registers
//   and the output queue. Throughput: one sample per cycle while req_full is
//   low, one result per block; decay multiply and level lookup each take one
//   pipeline stage behind a two-word queue, so a result can leave every cycle.
//   Stalls: if rsp_pop stays low the output queue fills, the back end holds,
//   the queue between front and back fills, and req_full rises.
//   Reset (synchronous): clears the block maximum, the block counter, the
//   held decay value and all queues; decay_coeff returns to 58982 and
//   floor_db to -40. Config writes (csr_we) are taken in any cycle and
//   should be made while the block is idle.
module block_peak_decay_db_meter #(
   parameter int BLOCK_SAMPLES = pdm_pkg::BLOCK_SAMPLES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [pdm_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [pdm_pkg::PEAK_W-1:0]          rsp_block_peak,
   output logic [pdm_pkg::DECAY_W-1:0]         rsp_decayed_peak,
   output logic signed [pdm_pkg::LEVEL_W-1:0]  rsp_level_db,
   input  logic                                csr_we,
   input  logic [pdm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pdm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pdm_pkg::*;

   logic              accept;
   logic              peak_push;
   logic [PEAK_W-1:0] peak_push_word;
   logic              mid_full;
   logic              mid_empty;
   logic              mid_pop;
   logic [PEAK_W-1:0] mid_word;
   logic              res_full;
   logic              res_push;
   result_type        res_word;
   logic [RESULT_W-1:0] out_word;
   result_type        out_res;

   assign req_full = mid_full;
   assign accept   = req_push && !mid_full;

   pdm_front #(
      .BLOCK_SAMPLES(BLOCK_SAMPLES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .sample    (req_sample),
      .peak_push (peak_push),
      .peak_word (peak_push_word)
   );

   // block maxima waiting for the back end
   pdm_queue #(
      .WIDTH(PEAK_W),
      .DEPTH(MID_DEPTH)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (peak_push),
      .wdata (peak_push_word),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_word),
      .empty (mid_empty)
   );

   pdm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .peak_empty (mid_empty),
      .peak_word  (mid_word),
      .peak_pop   (mid_pop),
      .res_full   (res_full),
      .res_push   (res_push),
      .res_word   (res_word)
   );

   // finished results waiting for the receiver
   pdm_queue #(
      .WIDTH(RESULT_W),
      .DEPTH(OUT_DEPTH)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_word),
      .full  (res_full),
      .pop   (rsp_pop),
      .rdata (out_word),
      .empty (rsp_empty)
   );

   assign out_res          = result_type'(out_word);
   assign rsp_block_peak   = out_res.block_peak;
   assign rsp_decayed_peak = out_res.decayed_peak;
   assign rsp_level_db     = out_res.level_db;

endmodule
